// File: sv/lphit_pkg.sv
`default_nettype none

package lphit_pkg;

   // slot count must stay a power of two: the home slot is the low key bits
   localparam int TABLE_SLOTS = 1024;
   localparam int KEY_BITS    = 64;
   localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);

   localparam int CMD_W      = 2;
   localparam int KEY_W      = 64;
   localparam int HEAD_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 10;

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_SKIP = 2'd3;

   localparam logic [HEAD_W-1:0] HEAD_EMPTY = 16'h0000;
   localparam logic [HEAD_W-1:0] HEAD_TOMB  = 16'hffff;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic probe;
      logic clear;
      logic rsp_load;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic quick;
      logic stop;
      logic clear_last;
   } dp_stat_type;

   function automatic logic head_valid(logic [HEAD_W-1:0] h);
      return (h != HEAD_EMPTY) && (h != HEAD_TOMB);
   endfunction

endpackage

`default_nettype wire

// File: sv/linear_probe_hash_index_table_core.sv
`default_nettype none

// channel   direction  handshake             word
// req       in         req_valid/req_ready   command, key, head_index
// rsp       out        rsp_valid/rsp_ready   status, slot, key_matched, found_head, link_index
//
// after reset a clear pass writes every head slot empty, one slot a cycle;
// req_ready stays low during it
// an operation runs through the accept, the probe of each slot in turn,
// then the hand-off to the rsp register;
// the slot memory has one read port, so the probe walks one slot per cycle
// command 3 or remove with a zero key skips the probe
// a full table walks all slots
// a finished word sits in the rsp register; the next req word is taken while
// it waits, and only the hand-off from result to rsp stalls on rsp_ready

module linear_probe_hash_index_table_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [lphit_pkg::CMD_W-1:0]           req_command,
   input  wire logic [lphit_pkg::KEY_W-1:0]           req_key,
   input  wire logic [lphit_pkg::HEAD_W-1:0]          req_head_index,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [lphit_pkg::STATUS_W-1:0]        rsp_status,
   output logic      [lphit_pkg::SLOT_OUT_W-1:0]      rsp_slot,
   output logic                                       rsp_key_matched,
   output logic      [lphit_pkg::HEAD_W-1:0]          rsp_found_head,
   output logic      [lphit_pkg::HEAD_W-1:0]          rsp_link_index
);

   // command and status between controller and datapath
   lphit_pkg::ctl_cmd_type cmd;
   lphit_pkg::dp_stat_type stat;

   // sequencer: clear pass, accept, probe walk, hand-off to rsp register
   lphit_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot memories, probe evaluation, result and rsp registers
   lphit_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_head_index  (req_head_index),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_key_matched (rsp_key_matched),
      .rsp_found_head  (rsp_found_head),
      .rsp_link_index  (rsp_link_index)
   );

endmodule

`default_nettype wire

// File: sv/lphit_ctl.sv
`default_nettype none

module lphit_ctl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire lphit_pkg::dp_stat_type stat,
   output lphit_pkg::ctl_cmd_type     cmd
);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_PROBE  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.accept   = accept;
      cmd.probe    = (state_ff == S_PROBE);
      cmd.clear    = (state_ff == S_CLEAR);
      cmd.rsp_load = (state_ff == S_FINISH) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = stat.quick ? S_FINISH : S_PROBE;
         end
         S_PROBE: begin
            if (stat.stop) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && out_free) |=> rsp_valid_ff)
      else $error("finished word not presented");

   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_PROBE || state_ff == S_FINISH))
      else $error("accepted word not processed");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response during clear pass");

   a_probe_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |=> (state_ff == S_PROBE || state_ff == S_FINISH))
      else $error("probe left to wrong state");

endmodule

`default_nettype wire

// File: sv/lphit_dp.sv
`default_nettype none

module lphit_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire lphit_pkg::ctl_cmd_type                cmd,
   output lphit_pkg::dp_stat_type                     stat,
   input  wire logic [lphit_pkg::CMD_W-1:0]           req_command,
   input  wire logic [lphit_pkg::KEY_W-1:0]           req_key,
   input  wire logic [lphit_pkg::HEAD_W-1:0]          req_head_index,
   output logic      [lphit_pkg::STATUS_W-1:0]        rsp_status,
   output logic      [lphit_pkg::SLOT_OUT_W-1:0]      rsp_slot,
   output logic                                       rsp_key_matched,
   output logic      [lphit_pkg::HEAD_W-1:0]          rsp_found_head,
   output logic      [lphit_pkg::HEAD_W-1:0]          rsp_link_index
);

   localparam int SB = lphit_pkg::SLOT_BITS;
   localparam int KB = lphit_pkg::KEY_BITS;
   localparam int HW = lphit_pkg::HEAD_W;
   localparam int SW = lphit_pkg::STATUS_W;

   logic [KB-1:0] key_mem  [lphit_pkg::TABLE_SLOTS];
   logic [HW-1:0] head_mem [lphit_pkg::TABLE_SLOTS];

   logic [lphit_pkg::CMD_W-1:0] op_ff;
   logic [KB-1:0]               key_ff;
   logic [HW-1:0]               hin_ff;
   logic [SB-1:0]               idx_ff, idx_next, cnt_ff, tomb_ff;
   logic                        have_tomb_ff;
   logic [KB-1:0]               rd_key_ff;
   logic [HW-1:0]               rd_head_ff;

   logic [SW-1:0]               res_status_ff;
   logic [SB-1:0]               res_slot_ff;
   logic                        res_matched_ff;
   logic [HW-1:0]               res_found_ff, res_link_ff;

   logic [SW-1:0]               rsp_status_ff;
   logic [SB-1:0]               rsp_slot_ff;
   logic                        rsp_matched_ff;
   logic [HW-1:0]               rsp_found_ff, rsp_link_ff;

   logic [KB-1:0] req_key_m;
   logic [SB-1:0] start_slot, rd_addr;
   logic          key_eq, hit, last, is_tomb, have_now, full;
   logic [SB-1:0] tomb_now, ch_slot;
   logic [HW-1:0] ch_head;
   logic          ch_matched;
   logic [SW-1:0] c_status;
   logic [HW-1:0] c_found, c_link;
   logic          c_wr_key, c_wr_head;
   logic [HW-1:0] c_head_val;
   logic          finish;
   logic          head_we, key_we;
   logic [SB-1:0] head_waddr;
   logic [HW-1:0] head_wdata;

   assign req_key_m  = req_key[KB-1:0];
   assign start_slot = SB'(req_key_m);
   assign idx_next   = idx_ff + SB'(1);
   assign rd_addr    = cmd.accept ? start_slot : idx_next;

   // probe evaluation on the slot read last cycle
   assign key_eq   = (rd_key_ff == key_ff);
   assign hit      = (rd_head_ff == lphit_pkg::HEAD_EMPTY) || key_eq;
   assign last     = (cnt_ff == SB'(lphit_pkg::TABLE_SLOTS - 1));
   assign is_tomb  = (rd_head_ff == lphit_pkg::HEAD_TOMB);
   assign tomb_now = is_tomb ? idx_ff : tomb_ff;
   assign have_now = have_tomb_ff || is_tomb;
   assign full     = !hit && !have_now;

   assign ch_slot    = hit ? idx_ff : tomb_now;
   assign ch_head    = hit ? rd_head_ff : lphit_pkg::HEAD_TOMB;
   assign ch_matched = hit && (rd_head_ff != lphit_pkg::HEAD_EMPTY) && key_eq;

   always_comb begin
      c_status   = lphit_pkg::STAT_MISS;
      c_found    = '0;
      c_link     = '0;
      c_wr_key   = 1'b0;
      c_wr_head  = 1'b0;
      c_head_val = hin_ff;
      if (full) begin
         c_status = lphit_pkg::STAT_FULL;
      end else begin
         case (op_ff)
            lphit_pkg::CMD_LOOKUP: begin
               if (lphit_pkg::head_valid(ch_head)) begin
                  c_status = lphit_pkg::STAT_DONE;
                  c_found  = ch_head;
               end
            end
            lphit_pkg::CMD_INSERT: begin
               if (ch_matched && lphit_pkg::head_valid(ch_head)) c_link = ch_head;
               c_wr_key  = 1'b1;
               c_wr_head = 1'b1;
               c_status  = lphit_pkg::STAT_DONE;
            end
            lphit_pkg::CMD_REMOVE: begin
               if (ch_head != lphit_pkg::HEAD_EMPTY && ch_head == hin_ff) begin
                  c_wr_head  = 1'b1;
                  c_head_val = lphit_pkg::HEAD_TOMB;
                  c_status   = lphit_pkg::STAT_DONE;
               end
            end
            default: c_status = lphit_pkg::STAT_MISS;
         endcase
      end
   end

   assign finish = cmd.probe && (hit || last);

   always_comb begin
      stat.quick = (req_command == lphit_pkg::CMD_NONE) ||
                   (req_command == lphit_pkg::CMD_REMOVE && req_key_m == '0);
      stat.stop       = hit || last;
      stat.clear_last = (idx_ff == SB'(lphit_pkg::TABLE_SLOTS - 1));
   end

   // memory ports
   assign head_we    = cmd.clear || (finish && c_wr_head);
   assign key_we     = finish && c_wr_key;
   assign head_waddr = cmd.clear ? idx_ff : ch_slot;
   assign head_wdata = cmd.clear ? lphit_pkg::HEAD_EMPTY : c_head_val;

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_waddr] <= head_wdata;
      if (key_we) key_mem[ch_slot] <= key_ff;
      rd_head_ff <= head_mem[rd_addr];
      rd_key_ff  <= key_mem[rd_addr];
   end

   // probe walk and clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         cnt_ff       <= '0;
         tomb_ff      <= '0;
         have_tomb_ff <= 1'b0;
      end else if (cmd.accept) begin
         idx_ff       <= start_slot;
         cnt_ff       <= '0;
         have_tomb_ff <= 1'b0;
      end else if (cmd.clear) begin
         idx_ff <= idx_next;
      end else if (cmd.probe && !(hit || last)) begin
         idx_ff       <= idx_next;
         cnt_ff       <= cnt_ff + SB'(1);
         tomb_ff      <= tomb_now;
         have_tomb_ff <= have_now;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff          <= req_command;
         key_ff         <= req_key_m;
         hin_ff         <= req_head_index;
         res_status_ff  <= (req_command == lphit_pkg::CMD_NONE) ?
                           lphit_pkg::STAT_MISS : lphit_pkg::STAT_SKIP;
         res_slot_ff    <= '0;
         res_matched_ff <= 1'b0;
         res_found_ff   <= '0;
         res_link_ff    <= '0;
      end else if (finish) begin
         res_status_ff  <= c_status;
         res_slot_ff    <= full ? '0 : ch_slot;
         res_matched_ff <= full ? 1'b0 : ch_matched;
         res_found_ff   <= c_found;
         res_link_ff    <= c_link;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_slot_ff    <= res_slot_ff;
         rsp_matched_ff <= res_matched_ff;
         rsp_found_ff   <= res_found_ff;
         rsp_link_ff    <= res_link_ff;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = lphit_pkg::SLOT_OUT_W'(rsp_slot_ff);
   assign rsp_key_matched = rsp_matched_ff;
   assign rsp_found_head  = rsp_found_ff;
   assign rsp_link_index  = rsp_link_ff;

endmodule

`default_nettype wire

// File: test/linear_probe_hash_index_table_core_tb.sv
`default_nettype none

module linear_probe_hash_index_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // generous bound: every word walking the whole table plus the longest gaps,
   // several times over, plus the clear pass after reset
   localparam int CYCLE_LIMIT  = 8_000_000;
   localparam int POOL_SIZE    = 40;
   localparam int RANDOM_WORDS = 680;
   localparam int SETTLE_WAIT  = 50;

   typedef struct packed {
      logic [lphit_pkg::CMD_W-1:0]  command;
      logic [lphit_pkg::KEY_W-1:0]  key;
      logic [lphit_pkg::HEAD_W-1:0] head_index;
   } req_word_type;

   typedef struct packed {
      logic [lphit_pkg::STATUS_W-1:0]   status;
      logic [lphit_pkg::SLOT_OUT_W-1:0] slot;
      logic                             key_matched;
      logic [lphit_pkg::HEAD_W-1:0]     found_head;
      logic [lphit_pkg::HEAD_W-1:0]     link_index;
   } rsp_word_type;

   logic                             clock          = 1'b0;
   logic                             reset          = 1'b1;
   logic                             req_valid      = 1'b0;
   logic                             req_ready;
   logic [lphit_pkg::CMD_W-1:0]      req_command    = lphit_pkg::CMD_NONE;
   logic [lphit_pkg::KEY_W-1:0]      req_key        = '0;
   logic [lphit_pkg::HEAD_W-1:0]     req_head_index = '0;
   logic                             rsp_valid;
   logic                             rsp_ready      = 1'b0;
   logic [lphit_pkg::STATUS_W-1:0]   rsp_status;
   logic [lphit_pkg::SLOT_OUT_W-1:0] rsp_slot;
   logic                             rsp_key_matched;
   logic [lphit_pkg::HEAD_W-1:0]     rsp_found_head;
   logic [lphit_pkg::HEAD_W-1:0]     rsp_link_index;

   // words waiting to be driven, and results owed by the block in order
   req_word_type req_backlog[$];
   rsp_word_type expected_rsps[$];

   // shadow copy of the slot memories, updated as each req word is taken
   logic [lphit_pkg::KEY_W-1:0]  shadow_keys  [lphit_pkg::TABLE_SLOTS];
   logic [lphit_pkg::HEAD_W-1:0] shadow_heads [lphit_pkg::TABLE_SLOTS];

   int mismatches = 0;
   int cycle_count = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   int req_calm = 0;
   int rsp_calm = 0;

   linear_probe_hash_index_table_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_head_index  (req_head_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_key_matched (rsp_key_matched),
      .rsp_found_head  (rsp_found_head),
      .rsp_link_index  (rsp_link_index)
   );

   always #5ns clock = ~clock;

   initial begin
      for (int i = 0; i < lphit_pkg::TABLE_SLOTS; i++) begin
         shadow_keys[i]  = '0;
         shadow_heads[i] = lphit_pkg::HEAD_EMPTY;
      end
   end

   // a head names a list only between empty and tombstone
   function automatic bit is_live_head(logic [lphit_pkg::HEAD_W-1:0] h);
      return (h != lphit_pkg::HEAD_EMPTY) && (h != lphit_pkg::HEAD_TOMB);
   endfunction

   // linear probe from the home slot: stop on empty or on a key hit,
   // otherwise fall back to the last tombstone passed; 0 means table full
   function automatic bit find_slot(input logic [lphit_pkg::KEY_W-1:0] key,
                                    output int where);
      int idx;
      int tomb;
      bit have_tomb;
      idx = int'(key[lphit_pkg::SLOT_BITS-1:0]);
      tomb = 0;
      have_tomb = 1'b0;
      where = 0;
      for (int n = 0; n < lphit_pkg::TABLE_SLOTS; n++) begin
         if (shadow_heads[idx] == lphit_pkg::HEAD_EMPTY || shadow_keys[idx] == key) begin
            where = idx;
            return 1'b1;
         end
         if (shadow_heads[idx] == lphit_pkg::HEAD_TOMB) begin
            tomb = idx;
            have_tomb = 1'b1;
         end
         idx = (idx + 1) % lphit_pkg::TABLE_SLOTS;
      end
      where = tomb;
      return have_tomb;
   endfunction

   // applies one command to the shadow table and returns the owed result
   function automatic rsp_word_type index_table_step(req_word_type w);
      rsp_word_type r;
      int s;
      logic [lphit_pkg::HEAD_W-1:0] h;
      r = '0;
      r.status = lphit_pkg::STAT_MISS;
      if (w.command == lphit_pkg::CMD_NONE)
         return r;
      if (w.command == lphit_pkg::CMD_REMOVE && w.key == '0) begin
         r.status = lphit_pkg::STAT_SKIP;
         return r;
      end
      if (!find_slot(w.key, s)) begin
         r.status = lphit_pkg::STAT_FULL;
         return r;
      end
      h = shadow_heads[s];
      r.slot = s[lphit_pkg::SLOT_OUT_W-1:0];
      r.key_matched = (h != lphit_pkg::HEAD_EMPTY) && (shadow_keys[s] == w.key);
      case (w.command)
         lphit_pkg::CMD_LOOKUP: begin
            if (is_live_head(h)) begin
               r.found_head = h;
               r.status = lphit_pkg::STAT_DONE;
            end
         end
         lphit_pkg::CMD_INSERT: begin
            // a live head of the same key becomes the chain link
            if (r.key_matched && is_live_head(h))
               r.link_index = h;
            shadow_keys[s]  = w.key;
            shadow_heads[s] = w.head_index;
            r.status = lphit_pkg::STAT_DONE;
         end
         default: begin
            if (h != lphit_pkg::HEAD_EMPTY && h == w.head_index) begin
               shadow_heads[s] = lphit_pkg::HEAD_TOMB;
               r.status = lphit_pkg::STAT_DONE;
            end
         end
      endcase
      return r;
   endfunction

   // mostly short gaps, a few long ones, and now and then a stretch of none
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 149) == 0)
         calm = $urandom_range(20, 80);
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void queue_req(logic [lphit_pkg::CMD_W-1:0] c,
                                     logic [lphit_pkg::KEY_W-1:0] k,
                                     logic [lphit_pkg::HEAD_W-1:0] h);
      req_word_type w;
      w.command = c;
      w.key = k;
      w.head_index = h;
      req_backlog.push_back(w);
   endfunction

   function automatic void check_field(string name, logic [lphit_pkg::HEAD_W-1:0] want,
                                       logic [lphit_pkg::HEAD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // any command code, the unused one included
   function automatic logic [lphit_pkg::CMD_W-1:0] any_command();
      return lphit_pkg::CMD_W'($urandom_range(0, 3));
   endfunction

   // req driver: a word is taken on valid and ready; the next one goes out
   // after a random gap, and the shadow table advances on each taken word
   always @(posedge clock) begin : req_driver
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            w.command = req_command;
            w.key = req_key;
            w.head_index = req_head_index;
            expected_rsps.push_back(index_table_step(w));
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            w = req_backlog.pop_front();
            req_command    <= w.command;
            req_key        <= w.key;
            req_head_index <= w.head_index;
            req_valid      <= 1'b1;
            req_gap = pick_gap(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // rsp monitor: each taken word is checked against the oldest owed result,
   // then ready may drop for a random stall
   always @(posedge clock) begin : rsp_monitor
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: rsp word with nothing owed, expected none, got status %0d slot %0d",
                        $time, rsp_status, rsp_slot);
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("slot", 16'(want.slot), 16'(rsp_slot));
               check_field("key_matched", 16'(want.key_matched), 16'(rsp_key_matched));
               check_field("found_head", want.found_head, rsp_found_head);
               check_field("link_index", want.link_index, rsp_link_index);
            end
            rsp_stall = pick_gap(rsp_calm);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_ready <= (rsp_stall == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      logic [lphit_pkg::KEY_W-1:0]  pool_keys  [POOL_SIZE];
      logic [lphit_pkg::HEAD_W-1:0] pool_heads [POOL_SIZE];
      int homes [8];
      int roll;
      int p;
      logic [lphit_pkg::HEAD_W-1:0] h;
      logic [lphit_pkg::KEY_W-1:0] k1, k2, k3, k4;

      homes = '{3, 4, 5, 200, 201, 1022, 1023, 0};
      k1 = 64'hA5A5_0000_0000_0100;
      k2 = 64'h0000_0000_0000_0500;   // same home slot as k1
      k3 = 64'h3333_0000_0000_0300;
      k4 = 64'h1444_0000_0000_0310;

      // directed part on a freshly cleared table
      queue_req(lphit_pkg::CMD_NONE, {$urandom, $urandom},
                16'(~$urandom_range(0, 65534)));
      queue_req(lphit_pkg::CMD_REMOVE, '0, 16'd5);           // zero key skipped
      queue_req(lphit_pkg::CMD_LOOKUP, 64'h1234_0000_0000_0040, '0);  // miss on empty
      queue_req(lphit_pkg::CMD_REMOVE, k1, lphit_pkg::HEAD_EMPTY);  // remove on empty
      queue_req(lphit_pkg::CMD_INSERT, k1, 16'd1);
      queue_req(lphit_pkg::CMD_LOOKUP, k1, '0);
      queue_req(lphit_pkg::CMD_INSERT, k1, 16'd65534);       // links to head 1
      queue_req(lphit_pkg::CMD_REMOVE, k1, 16'd7);           // head mismatch
      queue_req(lphit_pkg::CMD_REMOVE, k1, 16'd65534);       // tombstones the slot
      queue_req(lphit_pkg::CMD_LOOKUP, k1, '0);              // tombstone hit, miss
      queue_req(lphit_pkg::CMD_INSERT, k1, 16'd300);         // reuse tombstone, no link
      queue_req(lphit_pkg::CMD_INSERT, k2, 16'd2);           // collides, next slot
      queue_req(lphit_pkg::CMD_LOOKUP, k2, '0);
      queue_req(lphit_pkg::CMD_INSERT, '1, 16'h00ff);        // top slot
      queue_req(lphit_pkg::CMD_INSERT, 64'h0000_0000_0000_07ff, 16'hff00);  // wraps to 0
      queue_req(lphit_pkg::CMD_LOOKUP, 64'h0000_0000_0000_07ff, '0);
      queue_req(lphit_pkg::CMD_INSERT, k3, lphit_pkg::HEAD_EMPTY);  // head leaves it empty
      queue_req(lphit_pkg::CMD_LOOKUP, k3, '0);
      queue_req(lphit_pkg::CMD_INSERT, k4, lphit_pkg::HEAD_TOMB);   // head is a tombstone
      queue_req(lphit_pkg::CMD_LOOKUP, k4, '0);
      queue_req(lphit_pkg::CMD_REMOVE, k4, lphit_pkg::HEAD_TOMB);
      queue_req(lphit_pkg::CMD_INSERT, '0, 16'd9);           // zero key is legal for insert
      queue_req(lphit_pkg::CMD_LOOKUP, '0, '0);
      queue_req(lphit_pkg::CMD_NONE, '1, lphit_pkg::HEAD_TOMB);

      // key pool clustered on a few home slots so chains form and wrap
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_keys[i] = {$urandom, $urandom};
         pool_keys[i][lphit_pkg::SLOT_BITS-1:0] =
            (i % 8 == 7) ? lphit_pkg::SLOT_BITS'($urandom_range(0, 1023))
                         : lphit_pkg::SLOT_BITS'(homes[i % 8]);
         pool_heads[i] = lphit_pkg::HEAD_EMPTY;
      end

      // random part: mostly pool traffic, some noise keys and odd commands
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         roll = $urandom_range(0, 99);
         p = $urandom_range(0, POOL_SIZE - 1);
         if (roll < 35) begin
            if ($urandom_range(0, 49) == 0)
               h = ($urandom_range(0, 1) != 0) ? lphit_pkg::HEAD_TOMB : lphit_pkg::HEAD_EMPTY;
            else
               h = 16'($urandom_range(1, 65534));
            queue_req(lphit_pkg::CMD_INSERT, pool_keys[p], h);
            pool_heads[p] = is_live_head(h) ? h : lphit_pkg::HEAD_EMPTY;
         end else if (roll < 60) begin
            queue_req(lphit_pkg::CMD_LOOKUP, pool_keys[p], 16'($urandom));
         end else if (roll < 80) begin
            // remove with the head last given, so most of these hit
            h = (pool_heads[p] != lphit_pkg::HEAD_EMPTY) ? pool_heads[p]
                                                         : 16'($urandom_range(1, 65534));
            queue_req(lphit_pkg::CMD_REMOVE, pool_keys[p], h);
            pool_heads[p] = lphit_pkg::HEAD_EMPTY;
         end else if (roll < 85) begin
            queue_req(lphit_pkg::CMD_REMOVE, pool_keys[p], 16'($urandom_range(1, 65534)));
         end else if (roll < 88) begin
            queue_req(lphit_pkg::CMD_LOOKUP, {$urandom, $urandom}, 16'($urandom));
         end else if (roll < 90) begin
            queue_req(lphit_pkg::CMD_INSERT, {$urandom, $urandom},
                      16'($urandom_range(1, 65534)));
         end else if (roll < 93) begin
            queue_req(lphit_pkg::CMD_NONE, {$urandom, $urandom}, 16'($urandom));
         end else if (roll < 96) begin
            queue_req(lphit_pkg::CMD_REMOVE, '0, 16'($urandom));
         end else begin
            queue_req(any_command(), {$urandom, $urandom}, 16'($urandom));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent and every owed result seen
      do
         @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (SETTLE_WAIT) @(posedge clock);

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
